[sv/mdr_pkg.sv]
// Shared types and constants for the modular division block.
package mdr_pkg;

    localparam int MOD_BITS_DEF = 32;
    localparam int DATA_W       = 64;
    localparam int MODIN_W      = 32;
    localparam int ROOT_W       = 32;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RED_A,
        ST_RED_B,
        ST_FIX_A,
        ST_INV,
        ST_INV_CHK,
        ST_MUL,
        ST_DONE
    } state_t;

    // Datapath operation select
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_RED_A,
        OP_RED_B,
        OP_FIX_A,
        OP_INV,
        OP_MUL,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic init;
    } cmd_t;

    typedef struct packed {
        logic red_done;
        logic inv_done;
        logic mul_done;
        logic p_zero;
    } sts_t;

endpackage

[sv/mdr_datapath.sv]
// Datapath: bit-serial reductions, extended Euclid inverse with serial division, shift-add multiply.
module mdr_datapath #(
    parameter int MODULUS_BITS = mdr_pkg::MOD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mdr_pkg::cmd_t               cmd,
    output mdr_pkg::sts_t               sts,
    input  logic [mdr_pkg::DATA_W-1:0]  numerator,
    input  logic [mdr_pkg::DATA_W-1:0]  denominator,
    input  logic [mdr_pkg::MODIN_W-1:0] modulus,
    output logic [mdr_pkg::ROOT_W-1:0]  root
);
    localparam int W  = MODULUS_BITS;
    localparam int DW = mdr_pkg::DATA_W;
    localparam int CW = $clog2(2 * W + DW + 2);

    // Modulus, extended from the 32-bit field and masked to W bits
    logic [W-1:0] p_in;
    always_comb
    begin
        p_in = '0;
        for (int i = 0; i < W; i++)
        begin
            if (i < mdr_pkg::MODIN_W)
                p_in[i] = modulus[i];
        end
    end

    logic [W-1:0]    p_reg, p_next;
    logic [DW-1:0]   b_reg, b_next;       // denominator held for the second reduction
    logic [DW-1:0]   sh_reg, sh_next;     // value being shifted into a residue / dividend
    logic [W:0]      acc_reg, acc_next;   // running residue / product
    logic [W-1:0]    ra_reg, ra_next;     // residue of a
    logic            neg_reg, neg_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    // Extended Euclid: remainders r0,r1 with coefficients t0,t1 (mod p)
    logic [W-1:0]    r0_reg, r0_next, r1_reg, r1_next;
    logic [W-1:0]    t0_reg, t0_next, t1_reg, t1_next;
    logic [W-1:0]    rem_reg, rem_next;   // partial remainder of r0 / r1
    logic [W-1:0]    g_reg, g_next;       // gcd(b mod p, p)
    logic [W-1:0]    inv_reg, inv_next;
    logic [W-1:0]    res_reg, res_next;

    // Helpers
    function automatic logic [W-1:0] sub_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] p);
        begin
            if (x >= y)
                sub_m = x - y;
            else
                sub_m = p - (y - x);
        end
    endfunction

    // Shift one bit into residue: r = 2r + bit mod p (r < p)
    function automatic logic [W:0] dbl_add(input logic [W:0] r, input logic b,
                                           input logic [W-1:0] p);
        logic [W+1:0] t;
        begin
            t = {r, b};
            if (t >= {2'b0, p})
                t = t - {2'b0, p};
            dbl_add = t[W:0];
        end
    endfunction

    logic [W:0]   mt;
    logic [W+1:0] ms;
    logic [W:0]   rs;
    logic         qbit;

    always_comb
    begin
        p_next   = p_reg;
        b_next   = b_reg;
        sh_next  = sh_reg;
        acc_next = acc_reg;
        ra_next  = ra_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        r0_next  = r0_reg;
        r1_next  = r1_reg;
        t0_next  = t0_reg;
        t1_next  = t1_reg;
        rem_next = rem_reg;
        g_next   = g_reg;
        inv_next = inv_reg;
        res_next = res_reg;
        sts      = '0;
        mt       = '0;
        ms       = '0;
        rs       = '0;
        qbit     = 1'b0;
        unique case (cmd.op)
            mdr_pkg::OP_LOAD:
            begin
                p_next   = p_in;
                b_next   = denominator;
                neg_next = numerator[DW-1];
                sh_next  = numerator[DW-1] ? (~numerator + 1'b1) : numerator;
                acc_next = '0;
                cnt_next = CW'(DW);
            end
            mdr_pkg::OP_RED_A, mdr_pkg::OP_RED_B:
            begin
                if (cmd.init)
                begin
                    sh_next  = b_reg;
                    acc_next = '0;
                    cnt_next = CW'(DW);
                end
                else if (cnt_reg != '0)
                begin
                    acc_next = dbl_add(acc_reg, sh_reg[DW-1], p_reg);
                    sh_next  = {sh_reg[DW-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                end
                sts.red_done = (cnt_reg == '0) && !cmd.init;
            end
            mdr_pkg::OP_FIX_A:
            begin
                if (neg_reg && acc_reg[W-1:0] != '0)
                    ra_next = p_reg - acc_reg[W-1:0];
                else
                    ra_next = acc_reg[W-1:0];
            end
            mdr_pkg::OP_INV:
            begin
                if (cmd.init)
                begin
                    // r0 = p, r1 = b mod p; t0 = 0, t1 = 1 mod p
                    r0_next  = p_reg;
                    r1_next  = acc_reg[W-1:0];
                    t0_next  = '0;
                    t1_next  = (p_reg == W'(1)) ? '0 : W'(1);
                    rem_next = '0;
                    acc_next = '0;
                    sh_next  = '0;
                    sh_next[W-1:0] = p_reg;
                    cnt_next = CW'(W);
                end
                else if (r1_reg == '0)
                begin
                    sts.inv_done = 1'b1;
                    g_next   = r0_reg;
                    inv_next = t0_reg;
                end
                else if (cnt_reg != '0)
                begin
                    // One quotient bit: restoring division step, Horner update of q*t1 mod p
                    rs   = {rem_reg, sh_reg[W-1]};
                    qbit = (rs >= {1'b0, r1_reg});
                    if (qbit)
                        rs = rs - {1'b0, r1_reg};
                    mt = dbl_add(acc_reg, 1'b0, p_reg);
                    if (qbit)
                    begin
                        ms = {1'b0, mt} + {2'b0, t1_reg};
                        if (ms >= {2'b0, p_reg})
                            ms = ms - {2'b0, p_reg};
                        mt = ms[W:0];
                    end
                    acc_next = mt;
                    rem_next = rs[W-1:0];
                    sh_next  = {sh_reg[DW-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    // Quotient done: advance the remainder sequence
                    r0_next  = r1_reg;
                    r1_next  = rem_reg;
                    t0_next  = t1_reg;
                    t1_next  = sub_m(t0_reg, acc_reg[W-1:0], p_reg);
                    rem_next = '0;
                    acc_next = '0;
                    sh_next  = '0;
                    sh_next[W-1:0] = r1_reg;
                    cnt_next = CW'(W);
                end
            end
            mdr_pkg::OP_MUL:
            begin
                if (cmd.init)
                begin
                    acc_next = '0;
                    cnt_next = CW'(W);
                    sh_next  = '0;
                    sh_next[W-1:0] = ra_reg;
                end
                else if (cnt_reg != '0)
                begin
                    mt = dbl_add(acc_reg, 1'b0, p_reg);
                    if (sh_reg[W-1])
                    begin
                        ms = {1'b0, mt} + {2'b0, inv_reg};
                        if (ms >= {2'b0, p_reg})
                            ms = ms - {2'b0, p_reg};
                        mt = ms[W:0];
                    end
                    acc_next = mt;
                    sh_next  = {sh_reg[DW-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                end
                sts.mul_done = (cnt_reg == '0) && !cmd.init;
            end
            mdr_pkg::OP_FINISH:
            begin
                if (p_reg == '0)
                    res_next = '0;
                else if (g_reg != W'(1) && p_reg != W'(1))
                    res_next = p_reg;
                else
                    res_next = acc_reg[W-1:0];
            end
            default:
            begin
            end
        endcase
        sts.p_zero = (p_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        b_reg   <= b_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
        ra_reg  <= ra_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        r0_reg  <= r0_next;
        r1_reg  <= r1_next;
        t0_reg  <= t0_next;
        t1_reg  <= t1_next;
        rem_reg <= rem_next;
        g_reg   <= g_next;
        inv_reg <= inv_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        root = '0;
        for (int i = 0; i < mdr_pkg::ROOT_W; i++)
        begin
            if (i < W)
                root[i] = res_reg[i];
        end
    end

    // Residues stay below the modulus during the inverse and multiply, and after the fix of a
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == mdr_pkg::OP_INV && !cmd.init && p_reg != '0)
            |-> (t0_reg < p_reg && t1_reg < p_reg))
        else $error("inverse coefficient out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == mdr_pkg::OP_MUL && !cmd.init && p_reg != '0) |-> acc_reg < {1'b0, p_reg})
        else $error("product accumulator out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.op == mdr_pkg::OP_FIX_A) && p_reg != '0 |-> ra_reg < p_reg)
        else $error("residue of a out of range");
endmodule

[sv/mdr_ctrl.sv]
// Controller state machine sequencing reductions, inverse and multiply.
module mdr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output mdr_pkg::cmd_t cmd,
    input  mdr_pkg::sts_t sts
);
    mdr_pkg::state_t state_reg, state_next;
    logic            first_reg, first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mdr_pkg::ST_IDLE;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        first_next = 1'b0;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            mdr_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = mdr_pkg::OP_LOAD;
                    state_next = mdr_pkg::ST_RED_A;
                end
            end
            mdr_pkg::ST_RED_A:
            begin
                cmd.op = mdr_pkg::OP_RED_A;
                if (sts.p_zero)
                begin
                    cmd.op     = mdr_pkg::OP_FINISH;
                    state_next = mdr_pkg::ST_DONE;
                end
                else if (sts.red_done)
                    state_next = mdr_pkg::ST_FIX_A;
            end
            mdr_pkg::ST_FIX_A:
            begin
                cmd.op     = mdr_pkg::OP_FIX_A;
                state_next = mdr_pkg::ST_LOAD;
            end
            mdr_pkg::ST_LOAD:
            begin
                cmd.op     = mdr_pkg::OP_RED_B;
                cmd.init   = 1'b1;
                state_next = mdr_pkg::ST_RED_B;
            end
            mdr_pkg::ST_RED_B:
            begin
                cmd.op = mdr_pkg::OP_RED_B;
                if (sts.red_done)
                begin
                    first_next = 1'b1;
                    state_next = mdr_pkg::ST_INV;
                end
            end
            mdr_pkg::ST_INV:
            begin
                cmd.op   = mdr_pkg::OP_INV;
                cmd.init = first_reg;
                if (sts.inv_done)
                begin
                    first_next = 1'b1;
                    state_next = mdr_pkg::ST_MUL;
                end
            end
            mdr_pkg::ST_MUL:
            begin
                cmd.op   = mdr_pkg::OP_MUL;
                cmd.init = first_reg;
                if (sts.mul_done)
                    state_next = mdr_pkg::ST_INV_CHK;
            end
            mdr_pkg::ST_INV_CHK:
            begin
                cmd.op     = mdr_pkg::OP_FINISH;
                state_next = mdr_pkg::ST_DONE;
            end
            mdr_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = mdr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mdr_pkg::ST_IDLE;
            end
        endcase
    end

    // Only one side of the block is open at a time
    assert property (@(posedge clk) disable iff (!rst_n) !(out_valid && !in_stall))
        else $error("input open while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == mdr_pkg::ST_RED_A)
        else $error("accepted transaction did not start reduction");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> state_reg == mdr_pkg::ST_IDLE)
        else $error("delivered result did not return to idle");
endmodule

[sv/modular_division_root.sv]
// Top level: modular division a/b mod p, or p when b has no inverse.
// Usage:
//   Input channel (in_valid/in_stall) carries numerator (signed 64-bit),
//   denominator (64-bit) and modulus (32-bit). Output channel
//   (out_valid/out_stall) carries root. A transaction completes at a clock
//   edge with valid high and stall low.
//   One transaction is processed at a time. Before out_valid rises the
//   block runs two bit-serial reductions, S extended-Euclid steps of one
//   serial division each (S is at most about 1.44*MODULUS_BITS + 2), and a
//   MODULUS_BITS-step shift-add multiply; the Euclid divisions take most
//   of the time at the default width.
//   The next transaction can be taken in the cycle after the result is
//   delivered. A zero modulus skips the work: the controller goes from the
//   first reduction straight to the done state and raises out_valid with
//   root 0.
//   While the result waits under out_stall it holds steady and in_stall
//   stays high. Reset returns the controller to idle, ready for input.
module modular_division_root #(
    parameter int MODULUS_BITS = mdr_pkg::MOD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [mdr_pkg::DATA_W-1:0]  numerator,
    input  logic [mdr_pkg::DATA_W-1:0]  denominator,
    input  logic [mdr_pkg::MODIN_W-1:0] modulus,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mdr_pkg::ROOT_W-1:0]  root
);
    mdr_pkg::cmd_t cmd;
    mdr_pkg::sts_t sts;

    mdr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    mdr_datapath #(
        .MODULUS_BITS (MODULUS_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .numerator   (numerator),
        .denominator (denominator),
        .modulus     (modulus),
        .root        (root)
    );
endmodule

[sim/testbench.sv]
// Self-checking testbench for the modular division block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MODULUS_BITS = mdr_pkg::MOD_BITS_DEF;
    localparam int N_RANDOM     = 800;
    localparam int N_DIRECTED   = 18;

    // Directed row: numerator, denominator, modulus, typed expectation if known
    typedef struct packed {
        logic [mdr_pkg::DATA_W-1:0]  num;
        logic [mdr_pkg::DATA_W-1:0]  den;
        logic [mdr_pkg::MODIN_W-1:0] md;
        logic                        known;
        logic [mdr_pkg::ROOT_W-1:0]  exp_root;
    } vec_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [mdr_pkg::DATA_W-1:0]   numerator;
    logic [mdr_pkg::DATA_W-1:0]   denominator;
    logic [mdr_pkg::MODIN_W-1:0]  modulus;
    logic                         out_valid;
    logic                         out_stall;
    logic [mdr_pkg::ROOT_W-1:0]   root;

    logic [mdr_pkg::ROOT_W-1:0]   root_queue[$];
    int                           mismatches = 0;
    int                           tx_idle_pct;
    int                           rx_idle_pct;
    vec_t                         dir_tab[N_DIRECTED];

    modular_division_root #(.MODULUS_BITS(MODULUS_BITS)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .numerator   (numerator),
        .denominator (denominator),
        .modulus     (modulus),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .root        (root)
    );

    // Clock: 12 ns period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // x + y mod p, operands already reduced
    function automatic logic [63:0] madd(logic [63:0] x, logic [63:0] y, logic [63:0] p);
        logic [63:0] room;
        room = p - y;
        return (x >= room) ? (x - room) : (x + y);
    endfunction

    function automatic logic [63:0] msub(logic [63:0] x, logic [63:0] y, logic [63:0] p);
        return (x >= y) ? (x - y) : (p - (y - x));
    endfunction

    // Shift-and-add modular product
    function automatic logic [63:0] mmul(logic [63:0] x, logic [63:0] y, logic [63:0] p);
        logic [63:0] acc;
        acc = '0;
        for (int i = 63; i >= 0; i--)
        begin
            acc = madd(acc, acc, p);
            if (y[i])
                acc = madd(acc, x, p);
        end
        return acc;
    endfunction

    // Expected root for one transaction
    function automatic logic [mdr_pkg::ROOT_W-1:0] predict_root(logic [63:0] a,
                                                               logic [63:0] b,
                                                               logic [mdr_pkg::MODIN_W-1:0] m);
        logic [63:0] p, ra, mag, r0, r1, t0, t1, q, nr, nt, res;
        p = 64'(m);
        if (MODULUS_BITS < 64)
            p = p & ((64'd1 << MODULUS_BITS) - 1);
        if (p == 0)
            return '0;
        // signed residue of a
        if (!a[63])
            ra = a % p;
        else
        begin
            mag = ~a + 64'd1;
            ra  = mag % p;
            ra  = (ra != 0) ? (p - ra) : 64'd0;
        end
        // extended Euclid on (p, b mod p)
        r0 = p;
        r1 = b % p;
        t0 = 0;
        t1 = 64'd1 % p;
        while (r1 != 0)
        begin
            q  = r0 / r1;
            nr = r0 - q * r1;
            nt = msub(t0, mmul(q % p, t1, p), p);
            r0 = r1;
            r1 = nr;
            t0 = t1;
            t1 = nt;
        end
        if (r0 != 1)
            res = p;
        else
            res = mmul(t0, ra, p);
        return res[mdr_pkg::ROOT_W-1:0];
    endfunction

    // Drive one transaction and queue its expected root
    task automatic send_div(logic [63:0] a, logic [63:0] b, logic [mdr_pkg::MODIN_W-1:0] m,
                            logic known, logic [mdr_pkg::ROOT_W-1:0] typed_root);
        logic [mdr_pkg::ROOT_W-1:0] pr;
        pr = predict_root(a, b, m);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        numerator   <= a;
        denominator <= b;
        modulus     <= m;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        root_queue.push_back(known ? typed_root : pr);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random modulus: mostly small, some full width, odd/even/power of two
    function automatic logic [mdr_pkg::MODIN_W-1:0] rand_mod();
        int k;
        k = $urandom_range(9);
        case (k)
            0: return (mdr_pkg::MODIN_W)'(1) << $urandom_range(31);
            1: return $urandom() | 32'h8000_0000;
            2: return $urandom();
            3: return $urandom_range(2, 12);
            4: return 32'hFFFF_FFFB;
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    // Receiver: stall at random, check each transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (root_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected root %h", root);
                end
                else
                begin
                    logic [mdr_pkg::ROOT_W-1:0] want;
                    want = root_queue.pop_front();
                    if (root !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("root mismatch: expected %h got %h", want, root);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Stimulus
    initial
    begin
        logic [mdr_pkg::MODIN_W-1:0] m;
        int wait_cnt;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        numerator   = '0;
        denominator = '0;
        modulus     = 32'd7;
        tx_idle_pct = 12;
        rx_idle_pct = 66;

        dir_tab[0]  = '{64'd6, 64'd3, 32'd7, 1'b0, '0};
        dir_tab[1]  = '{64'd5, 64'd9, 32'd1, 1'b1, 32'd0};
        dir_tab[2]  = '{64'd5, 64'd0, 32'd7, 1'b1, 32'd7};
        dir_tab[3]  = '{64'd5, 64'd14, 32'd7, 1'b1, 32'd7};
        dir_tab[4]  = '{64'd5, 64'd4, 32'd12, 1'b1, 32'd12};
        dir_tab[5]  = '{64'd5, 64'd6, 32'd12, 1'b1, 32'd12};
        dir_tab[6]  = '{64'd5, 64'd7, 32'd12, 1'b0, '0};
        dir_tab[7]  = '{64'h8000_0000_0000_0000, 64'd1, 32'd7, 1'b0, '0};
        dir_tab[8]  = '{64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 32'hFFFF_FFFF, 1'b0, '0};
        dir_tab[9]  = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 32'd10, 1'b1, 32'd9};
        dir_tab[10] = '{64'd0, 64'd3, 32'd11, 1'b1, 32'd0};
        dir_tab[11] = '{64'd3, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFB, 1'b0, '0};
        dir_tab[12] = '{64'd3, 64'd3, 32'h8000_0000, 1'b1, 32'd1};
        dir_tab[13] = '{64'd3, 64'd2, 32'h8000_0000, 1'b1, 32'h8000_0000};
        dir_tab[14] = '{64'd1, 64'd1, 32'd2, 1'b1, 32'd1};
        dir_tab[15] = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                        32'hFFFF_FFFF, 1'b0, '0};
        dir_tab[16] = '{64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA,
                        32'hAAAA_5555, 1'b0, '0};
        dir_tab[17] = '{64'd1, 64'd2, 32'd3, 1'b1, 32'd2};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_div(dir_tab[i].num, dir_tab[i].den, dir_tab[i].md,
                     dir_tab[i].known, dir_tab[i].exp_root);

        // Hold off until the block has drained
        in_valid <= 1'b0;
        while (root_queue.size() != 0)
            @(posedge clk);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 3)
            begin
                tx_idle_pct = 66;
                rx_idle_pct = 12;
            end
            if (i == 2 * N_RANDOM / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            m = rand_mod();
            send_div(rand64(), ($urandom_range(3) == 0) ? 64'($urandom_range(20)) : rand64(),
                     m, 1'b0, '0);
        end
        in_valid <= 1'b0;

        wait_cnt = 0;
        while (root_queue.size() != 0 && wait_cnt < 200000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (300) @(posedge clk);
        if (mismatches == 0 && root_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #200ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[modular_division_root.f]
sv/mdr_pkg.sv
sv/mdr_datapath.sv
sv/mdr_ctrl.sv
sv/modular_division_root.sv
sim/testbench.sv
